// ===== design/gpi_pkg.sv =====
// Package: shared constants, codes, control types and index helpers of the interpreter.
`timescale 1ns / 1ps
package gpi_pkg;

	// Geometry of the register file
	localparam int LANES     = 64;
	localparam int REGISTERS = 8;
	localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int REG_W     = $clog2(REGISTERS);
	localparam int RF_DEPTH  = REGISTERS * LANES;
	localparam int RF_AW     = $clog2(RF_DEPTH);

	// Divide table, addressed by {dividend, divisor}
	localparam int TBL_DEPTH = 256 * 256;
	localparam int TBL_AW    = 16;

	localparam logic [7:0] LIMIT_RESET = 8'd127;

	typedef enum logic [1:0] {
		KIND_EXEC = 2'd0,
		KIND_WREG = 2'd1,
		KIND_WTBL = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN,
		ST_RD_WAIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture instruction fields, rewind lane counter
		logic wr_reg;   // host write of one register byte
		logic wr_tbl;   // host write of one divide table byte
		logic rd_reg;   // host read of one register byte
		logic issue;    // issue operand reads for the current lane
		logic out_load; // move register read data into the output register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_lane;
		logic pipe_busy;
		logic out_full;
	} ctl_sts_t;

	// Register number modulo REGISTERS (constant lookup)
	function automatic logic [REG_W-1:0] reg_wrap(input logic [7:0] v);
		logic [REG_W-1:0] r;
		r = '0;
		for (int i = 0; i < 256; i++) begin
			if (v == 8'(i))
				r = REG_W'(i % REGISTERS);
		end
		return r;
	endfunction

	// Lane number modulo LANES (constant lookup)
	function automatic logic [LANE_W-1:0] lane_wrap(input logic [5:0] v);
		logic [LANE_W-1:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (v == 6'(i))
				r = LANE_W'(i % LANES);
		end
		return r;
	endfunction

	// Flat register file address: reg * LANES + lane
	function automatic logic [RF_AW-1:0] rf_addr(input logic [REG_W-1:0] r,
			input logic [LANE_W-1:0] l);
		return RF_AW'(RF_AW'(r) * RF_AW'(LANES) + RF_AW'(l));
	endfunction

endpackage

// ===== design/gpi_if.sv =====
// Interfaces: instruction, result and configuration channels.
`timescale 1ns / 1ps
interface gpi_instr_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  dest_reg;
	logic [2:0]  source_reg;
	logic [1:0]  opcode;
	logic [7:0]  operand_code;
	logic [5:0]  lane;
	logic [7:0]  data;
	logic [15:0] table_index;

	modport source (output valid, kind, dest_reg, source_reg, opcode, operand_code, lane,
		data, table_index, input ready);
	modport sink (input valid, kind, dest_reg, source_reg, opcode, operand_code, lane,
		data, table_index, output ready);
endinterface

interface gpi_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

interface gpi_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] immediate_limit;

	modport source (output valid, immediate_limit, input ready);
	modport sink (input valid, immediate_limit, output ready);
endinterface

// ===== design/gpi_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module gpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== design/gpi_ctrl.sv =====
// Controller: sequences host accesses and the per-lane sweep of an instruction.
`timescale 1ns / 1ps
module gpi_ctrl
	import gpi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	output logic       in_ready,
	input  ctl_sts_t   sts,
	output ctl_cmd_t   cmd
);

	state_t state_q, state_d;
	kind_t  kind;

	assign kind = kind_t'(in_kind);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// a read needs the output register free when its data returns
				in_ready = !(kind == KIND_READ && sts.out_full);
				if (in_valid && in_ready) begin
					unique case (kind)
						KIND_EXEC: begin
							cmd.load = 1'b1;
							state_d  = ST_EXEC;
						end
						KIND_WREG: cmd.wr_reg = 1'b1;
						KIND_WTBL: cmd.wr_tbl = 1'b1;
						KIND_READ: begin
							cmd.rd_reg = 1'b1;
							state_d    = ST_RD_WAIT;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: begin
				cmd.issue = 1'b1;
				if (sts.last_lane)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy)
					state_d = ST_IDLE;
			end
			ST_RD_WAIT: begin
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// the output register is only loaded when it is empty
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full)
		else $error("output register overwritten");

	// the sweep ends right after the last lane is issued
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && sts.last_lane) |=> (state_q == ST_DRAIN))
		else $error("lane sweep did not stop at last lane");

	// a sweep leaves no issue behind once drained
	a_no_issue_outside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (state_q == ST_EXEC))
		else $error("lane issued outside sweep");
`endif

endmodule

// ===== design/gpi_dpath.sv =====
// Datapath: register file, divide table, lane pipeline and output register.
`timescale 1ns / 1ps
module gpi_dpath
	import gpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output ctl_sts_t    sts,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  source_reg,
	input  logic [1:0]  opcode,
	input  logic [7:0]  operand_code,
	input  logic [5:0]  lane,
	input  logic [7:0]  data,
	input  logic [15:0] table_index,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_limit,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  read_data
);

	logic [7:0]        limit_q;
	logic [REG_W-1:0]  dst_q, src_q, opr_q;
	op_t               op_q;
	logic              imm_q;
	logic [7:0]        code_q;
	logic [LANE_W-1:0] lane_q, lane_s2, lane_s3;
	logic              v_s2, v_s3;
	logic [7:0]        res_s3;
	logic              out_valid_q;
	logic [7:0]        read_data_q;

	logic [RF_AW-1:0]  rfa_raddr, rfb_raddr, rf_waddr;
	logic [7:0]        rf_wdata, rfa_rdata, rfb_rdata, tbl_rdata;
	logic              rf_we, rfa_re;
	logic [REG_W-1:0]  host_reg;
	logic [LANE_W-1:0] host_lane;
	logic [7:0]        opnd_b;
	logic [15:0]       prod;
	logic [7:0]        res_d;

	// Operand limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (cfg_we)
			limit_q <= cfg_limit;
	end

	// Instruction fields, captured at acceptance
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dst_q  <= reg_wrap(8'(dest_reg));
			src_q  <= reg_wrap(8'(source_reg));
			opr_q  <= reg_wrap(8'(operand_code - limit_q - 8'd1));
			op_q   <= op_t'(opcode);
			imm_q  <= (operand_code <= limit_q);
			code_q <= operand_code;
		end
	end

	// Lane counter and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (cmd.load)
				lane_q <= '0;
			else if (cmd.issue)
				lane_q <= lane_q + LANE_W'(1);
			v_s2 <= cmd.issue;
			v_s3 <= v_s2;
		end
	end

	assign sts.last_lane = (lane_q == LANE_W'(LANES - 1));
	assign sts.pipe_busy = v_s2 | v_s3;
	assign sts.out_full  = out_valid_q;

	// Host access addressing
	assign host_reg  = reg_wrap(8'(dest_reg));
	assign host_lane = lane_wrap(lane);

	// Read ports: port A serves source operand and host reads, port B the operand register
	assign rfa_re    = cmd.rd_reg | cmd.issue;
	assign rfa_raddr = cmd.rd_reg ? rf_addr(host_reg, host_lane) : rf_addr(src_q, lane_q);
	assign rfb_raddr = rf_addr(opr_q, lane_q);

	// Write port: host write or pipeline writeback
	assign rf_we    = cmd.wr_reg | v_s3;
	assign rf_waddr = cmd.wr_reg ? rf_addr(host_reg, host_lane) : rf_addr(dst_q, lane_s3);
	assign rf_wdata = cmd.wr_reg ? data : ((op_q == OP_DIV) ? tbl_rdata : res_s3);

	gpi_ram #(.WIDTH(8), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (rfa_re),
		.raddr (rfa_raddr),
		.rdata (rfa_rdata)
	);

	// mirror copy for the second operand read
	gpi_ram #(.WIDTH(8), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (cmd.issue),
		.raddr (rfb_raddr),
		.rdata (rfb_rdata)
	);

	// Stage 2: ALU on operand bytes, divide table lookup
	assign opnd_b = imm_q ? code_q : rfb_rdata;
	assign prod   = 16'(rfa_rdata) * 16'(opnd_b);

	always_comb begin
		case (op_q)
			OP_ADD:  res_d = 8'(rfa_rdata + opnd_b);
			OP_SUB:  res_d = 8'(rfa_rdata - opnd_b);
			OP_MUL:  res_d = prod[7:0];
			default: res_d = 8'd0;
		endcase
	end

	gpi_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_tbl (
		.clk   (clk),
		.we    (cmd.wr_tbl),
		.waddr (table_index),
		.wdata (data),
		.re    (v_s2),
		.raddr ({rfa_rdata, opnd_b}),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk) begin
		lane_s2 <= lane_q;
		lane_s3 <= lane_s2;
		res_s3  <= res_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			read_data_q <= rfa_rdata;
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

`ifndef SYNTHESIS
	// host register writes never collide with pipeline writeback
	a_rf_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_reg && v_s3))
		else $error("register write collision");

	// divide table is never written during a sweep lookup
	a_tbl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_tbl && v_s2))
		else $error("table write during lookup");

	// writeback follows an issue through the v_s2 and v_s3 registers
	a_wb_timing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> ##1 v_s3)
		else $error("writeback lost");
`endif

endmodule

// ===== design/simd_gp_byte_register_interpreter_unit.sv =====
// Top level: byte register interpreter for linear genetic programming.
//
//  channel  direction  payload                                        accepted when
//  instr    in         kind dest_reg source_reg opcode operand_code   valid & ready
//                      lane data table_index
//  result   out        read_data                                      valid & ready
//  cfg      in         immediate_limit                                valid & ready
//
// An execute item sweeps all LANES lanes, one lane per cycle through a three-stage
// pipeline (operand read, ALU or table lookup, writeback); the next item is accepted
// only once the pipeline has drained. Register and table writes finish at acceptance;
// a read passes ST_RD_WAIT into the output register, then waits on the result handshake.
// Reset clears control state only; register file and table hold nothing until written.
// A pending result does not block writes or executes; a new read waits for it.
`timescale 1ns / 1ps
module simd_gp_byte_register_interpreter_unit
	import gpi_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	gpi_instr_if.sink    instr,
	gpi_result_if.source result,
	gpi_cfg_if.sink      cfg
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	assign cfg.ready = 1'b1;

	gpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (instr.valid),
		.in_kind  (instr.kind),
		.in_ready (instr.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gpi_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.dest_reg     (instr.dest_reg),
		.source_reg   (instr.source_reg),
		.opcode       (instr.opcode),
		.operand_code (instr.operand_code),
		.lane         (instr.lane),
		.data         (instr.data),
		.table_index  (instr.table_index),
		.cfg_we       (cfg.valid),
		.cfg_limit    (cfg.immediate_limit),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.read_data    (result.read_data)
	);

endmodule

// ===== test/testbench.sv =====
// Testbench: self-checking stimulus, state mirror and read-back checks for the byte interpreter.
`timescale 1ns / 1ps
module testbench;
	import gpi_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = LANES + 8;
	localparam int RANDOM_ITEMS = 300;

	// One access as it travels on the instruction channel
	typedef struct {
		kind_t       kind;
		logic [2:0]  dest;
		logic [2:0]  src;
		op_t         op;
		logic [7:0]  code;
		logic [5:0]  lane;
		logic [7:0]  data;
		logic [15:0] tidx;
	} access_t;

	logic clk;
	logic arst_n;

	gpi_instr_if  instr_ch ();
	gpi_result_if result_ch ();
	gpi_cfg_if    cfg_ch ();

	simd_gp_byte_register_interpreter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of register file, divide table and immediate limit
	logic [7:0] reg_bytes [REGISTERS][LANES];
	logic [7:0] div_bytes [TBL_DEPTH];
	bit         div_loaded [TBL_DEPTH];
	logic [7:0] limit_q;

	// Bytes still owed by outstanding reads, oldest first
	logic [7:0] read_bytes_q [$];

	int errors;
	int shown;
	bit steady;
	int n_exec, n_div, n_wreg, n_wtbl, n_read, n_checked, n_limits;
	int sent;
	int quiet_cycles;
	int res_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (shown < 40) begin
			shown++;
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endtask

	// Second operand of one lane: constant, or register (code - limit - 1) mod REGISTERS
	function automatic logic [7:0] second_byte(input logic [7:0] code, input int lane);
		int r;
		if (code > limit_q) begin
			r = (int'(code) - int'(limit_q) - 1) % REGISTERS;
			return reg_bytes[r][lane];
		end
		return code;
	endfunction

	// Apply one accepted item to the mirror; reads queue the byte they must return
	function automatic void predict_access(input access_t a);
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] prod;
		int          d;
		int          s;
		int          l;
		d = int'(a.dest) % REGISTERS;
		s = int'(a.src) % REGISTERS;
		l = int'(a.lane) % LANES;
		case (a.kind)
			KIND_EXEC: begin
				n_exec++;
				if (a.op == OP_DIV)
					n_div++;
				// each lane reads and writes only itself, so dest may alias an operand
				for (int j = 0; j < LANES; j++) begin
					x = reg_bytes[s][j];
					y = second_byte(a.code, j);
					case (a.op)
						OP_ADD: reg_bytes[d][j] = x + y;
						OP_SUB: reg_bytes[d][j] = x - y;
						OP_MUL: begin
							prod = 16'(x) * 16'(y);
							reg_bytes[d][j] = prod[7:0];
						end
						default: reg_bytes[d][j] = div_bytes[{x, y}];
					endcase
				end
			end
			KIND_WREG: begin
				n_wreg++;
				reg_bytes[d][l] = a.data;
			end
			KIND_WTBL: begin
				n_wtbl++;
				div_bytes[a.tidx] = a.data;
				div_loaded[a.tidx] = 1'b1;
			end
			default: begin
				n_read++;
				read_bytes_q.push_back(reg_bytes[d][l]);
			end
		endcase
	endfunction

	// All fields random; callers override what the access uses
	function automatic access_t rand_access(input kind_t k);
		access_t a;
		a.kind = k;
		a.dest = 3'($urandom);
		a.src  = 3'($urandom);
		a.op   = op_t'($urandom_range(0, 3));
		a.code = 8'($urandom);
		a.lane = 6'($urandom);
		a.data = 8'($urandom);
		a.tidx = 16'($urandom);
		return a;
	endfunction

	// Send one item, predict it once it is accepted; valid stays high for a back-to-back item
	task automatic send_access(input access_t a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid        <= 1'b1;
		instr_ch.kind         <= a.kind;
		instr_ch.dest_reg     <= a.dest;
		instr_ch.source_reg   <= a.src;
		instr_ch.opcode       <= a.op;
		instr_ch.operand_code <= a.code;
		instr_ch.lane         <= a.lane;
		instr_ch.data         <= a.data;
		instr_ch.table_index  <= a.tidx;
		do @(posedge clk); while (!instr_ch.ready);
		predict_access(a);
		sent++;
	endtask

	task automatic write_byte(input logic [2:0] r, input logic [5:0] l, input logic [7:0] v);
		access_t a;
		a = rand_access(KIND_WREG);
		a.dest = r;
		a.lane = l;
		a.data = v;
		send_access(a);
	endtask

	task automatic read_byte(input logic [2:0] r, input logic [5:0] l);
		access_t a;
		a = rand_access(KIND_READ);
		a.dest = r;
		a.lane = l;
		send_access(a);
	endtask

	// A divide looks up one table entry per lane; load any entry not yet written
	task automatic load_divide_entries(input access_t ins);
		access_t     w;
		logic [15:0] idx;
		for (int j = 0; j < LANES; j++) begin
			idx = {reg_bytes[int'(ins.src) % REGISTERS][j], second_byte(ins.code, j)};
			if (!div_loaded[idx]) begin
				w = rand_access(KIND_WTBL);
				w.tidx = idx;
				send_access(w);
			end
		end
	endtask

	task automatic run_instruction(input logic [2:0] d, input logic [2:0] s, input op_t op,
			input logic [7:0] code);
		access_t a;
		a = rand_access(KIND_EXEC);
		a.dest = d;
		a.src  = s;
		a.op   = op;
		a.code = code;
		if (op == OP_DIV)
			load_divide_entries(a);
		send_access(a);
	endtask

	// Stop sending, wait for every owed read, then let a full lane sweep finish
	task automatic drain_block();
		instr_ch.valid <= 1'b0;
		while (read_bytes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_immediate_limit(input logic [7:0] v);
		drain_block();
		cfg_ch.valid           <= 1'b1;
		cfg_ch.immediate_limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_q = v;
		n_limits++;
	endtask

	// Compare one returned byte with the oldest owed read
	task automatic check_read(input logic [7:0] got);
		logic [7:0] want;
		if (read_bytes_q.size() == 0) begin
			report_mismatch($sformatf("read_data %02h with no read outstanding", got));
		end else begin
			want = read_bytes_q.pop_front();
			n_checked++;
			if (got !== want)
				report_mismatch($sformatf("read_data %02h, expected %02h", got, want));
		end
	endtask

	// Result side: random back-pressure, check on each handshake
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_read(result_ch.read_data);
		if (res_stall > 0) begin
			res_stall--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			res_stall = pick_gap();
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	// Every register byte gets written before anything reads it
	task automatic test_load_registers();
		for (int r = 0; r < REGISTERS; r++)
			for (int l = 0; l < LANES; l++)
				write_byte(3'(r), 6'(l), 8'($urandom));
	endtask

	// Extremes and boundary operand codes at the reset limit of 127
	task automatic test_directed();
		write_byte(3'd7, 6'd63, 8'hff);
		write_byte(3'd0, 6'd0, 8'h00);
		read_byte(3'd7, 6'd63);
		read_byte(3'd0, 6'd0);
		run_instruction(3'd1, 3'd7, OP_ADD, 8'd0);   // constant zero
		run_instruction(3'd2, 3'd7, OP_ADD, 8'd127); // code equal to limit is still a constant
		run_instruction(3'd3, 3'd1, OP_ADD, 8'd128); // first register code: r0
		run_instruction(3'd4, 3'd3, OP_SUB, 8'd255); // top code wraps onto r7
		run_instruction(3'd5, 3'd5, OP_SUB, 8'd133); // dest, source and operand all r5
		run_instruction(3'd6, 3'd7, OP_MUL, 8'd255);
		run_instruction(3'd6, 3'd6, OP_MUL, 8'd134); // square of r6 in place
		run_instruction(3'd0, 3'd4, OP_DIV, 8'd200); // operand register wraps onto r0
		run_instruction(3'd1, 3'd2, OP_DIV, 8'd3);
		for (int r = 0; r < REGISTERS; r++)
			read_byte(3'(r), (r % 2) ? 6'd63 : 6'd0);
		read_byte(3'd1, 6'd31);
	endtask

	// Limit at both ends, then back to the reset value
	task automatic test_limit_extremes();
		set_immediate_limit(8'd0);
		run_instruction(3'd2, 3'd3, OP_ADD, 8'd0);   // only constant left
		run_instruction(3'd3, 3'd2, OP_SUB, 8'd1);   // r0
		run_instruction(3'd4, 3'd4, OP_MUL, 8'd255); // r6
		run_instruction(3'd5, 3'd1, OP_DIV, 8'd9);   // r0
		read_byte(3'd3, 6'd0);
		read_byte(3'd5, 6'd63);
		set_immediate_limit(8'd255);
		run_instruction(3'd6, 3'd0, OP_ADD, 8'd255); // every code a constant
		run_instruction(3'd7, 3'd6, OP_DIV, 8'd255);
		read_byte(3'd6, 6'd17);
		read_byte(3'd7, 6'd40);
		set_immediate_limit(LIMIT_RESET);
	endtask

	// Mostly instructions, most followed by readback, with loose writes, reads and noise
	task automatic test_random();
		int         start;
		int         next_cfg;
		int         roll;
		int         nreads;
		bit         paused;
		op_t        op;
		logic [2:0] d;
		logic [5:0] l;
		access_t    a;
		start    = sent;
		next_cfg = sent + $urandom_range(100, 200);
		paused   = 1'b0;
		while (sent - start < RANDOM_ITEMS) begin
			if (sent >= next_cfg) begin
				case ($urandom_range(0, 3))
					0: set_immediate_limit(8'd0);
					1: set_immediate_limit(8'd255);
					2: set_immediate_limit(LIMIT_RESET);
					default: set_immediate_limit(8'($urandom));
				endcase
				next_cfg = sent + $urandom_range(100, 200);
			end
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			// one pause halfway until all owed reads are back
			if (!paused && sent - start >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				drain_block();
			end
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				op = ($urandom_range(0, 99) < 8) ? OP_DIV : op_t'($urandom_range(0, 2));
				d  = 3'($urandom);
				run_instruction(d, 3'($urandom), op, 8'($urandom));
				nreads = (roll < 45) ? $urandom_range(1, 3) : 0;
				for (int i = 0; i < nreads; i++)
					read_byte(d, 6'($urandom));
			end else if (roll < 70) begin
				d = 3'($urandom);
				l = 6'($urandom);
				write_byte(d, l, 8'($urandom));
				if ($urandom_range(0, 1))
					read_byte(d, l);
			end else if (roll < 82) begin
				read_byte(3'($urandom), 6'($urandom));
			end else begin
				a = rand_access(KIND_WTBL);
				send_access(a);
			end
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		instr_ch.valid        = 1'b0;
		instr_ch.kind         = 2'd0;
		instr_ch.dest_reg     = 3'd0;
		instr_ch.source_reg   = 3'd0;
		instr_ch.opcode       = 2'd0;
		instr_ch.operand_code = 8'd0;
		instr_ch.lane         = 6'd0;
		instr_ch.data         = 8'd0;
		instr_ch.table_index  = 16'd0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.immediate_limit = 8'd0;
		result_ch.ready       = 1'b0;
		limit_q               = LIMIT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_registers();
		test_directed();
		test_limit_extremes();
		test_random();
		drain_block();

		$display({"covered %0d items: %0d executes (%0d divides), ",
			"%0d register writes, %0d table writes, %0d reads"},
			sent, n_exec, n_div, n_wreg, n_wtbl, n_read);
		$display("%0d limit settings applied, %0d read bytes checked, %0d mismatches",
			n_limits, n_checked, errors);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== simd_gp_byte_register_interpreter_unit.f =====
design/gpi_pkg.sv
design/gpi_if.sv
design/gpi_ram.sv
design/gpi_ctrl.sv
design/gpi_dpath.sv
design/simd_gp_byte_register_interpreter_unit.sv
test/testbench.sv
